>>> rtl/core/regex_pattern_tokenizer_unit_assert.svh
// assertion macros used by the tokenizer top module
`ifndef REGEX_PATTERN_TOKENIZER_UNIT_ASSERT_SVH
`define REGEX_PATTERN_TOKENIZER_UNIT_ASSERT_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define RPT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpt implication check failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define RPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpt next-cycle check failed");

`endif

>>> rtl/core/rpt_pkg.sv
`default_nettype none

package rpt_pkg;

  // number of codes in a character class set
  localparam int unsigned SET_W  = 128;
  localparam int unsigned CHAR_W = 7;

  // token kinds
  typedef enum logic [3:0] {
    KIND_CHAR     = 4'd0,
    KIND_CLASS    = 4'd1,
    KIND_LPAREN   = 4'd2,
    KIND_RPAREN   = 4'd3,
    KIND_STAR     = 4'd4,
    KIND_PIPE     = 4'd5,
    KIND_PLUS     = 4'd6,
    KIND_QUESTION = 4'd7,
    KIND_END      = 4'd8
  } kind_t;

  // one output token
  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  literal;
    logic [SET_W-1:0]   set;
    logic               last;
  } rpt_token_t;

  // tokens caused by one character, in order
  typedef struct packed {
    rpt_token_t  tok0;
    rpt_token_t  tok1;
    logic [1:0]  count;
  } rpt_burst_t;

endpackage

`default_nettype wire

>>> rtl/core/regex_pattern_tokenizer_unit.sv
// output: a token is presented in the cycle after its character is accepted
// throughput: one character per cycle while out_tready is high; a character that
//   yields two tokens (only the last one of a pattern) holds the input off
//   until the first of them leaves the two-entry output register
// reset: synchronous active-low rst_n returns the lexer to normal mode with an
//   empty class and empties the output register
`default_nettype none

module regex_pattern_tokenizer_unit
  import rpt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [6:0] character, [7] zero
  input  wire logic          in_tlast,   // end_of_pattern
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [135:0]       out_tdata,  // [6:0] literal, [70:7] set_low,
                                         // [134:71] set_high, [135] zero
  output logic [3:0]         out_tuser,  // [3:0] kind
  output logic               out_tlast   // last_of_run
);

  `include "regex_pattern_tokenizer_unit_assert.svh"

  rpt_burst_t  burst;
  logic        in_accept, pop;
  logic [1:0]  cnt_r, cnt_nxt;
  rpt_token_t  tok0_r, tok0_nxt, tok1_r, tok1_nxt;

  rpt_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_char   (in_tdata[CHAR_W-1:0]),
    .in_last   (in_tlast),
    .burst     (burst)
  );

  // handshakes: room when empty or when the single held word leaves now
  assign pop       = out_tvalid && out_tready;
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_accept = in_tvalid && in_tready;

  // output register next values
  always_comb begin
    cnt_nxt  = cnt_r;
    tok0_nxt = tok0_r;
    tok1_nxt = tok1_r;
    if (in_accept) begin
      cnt_nxt  = burst.count;
      tok0_nxt = burst.tok0;
      tok1_nxt = burst.tok1;
    end else if (pop) begin
      cnt_nxt  = cnt_r - 2'd1;
      tok0_nxt = tok1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok0_r <= tok0_nxt;
    tok1_r <= tok1_nxt;
  end

  // output word
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {1'b0, tok0_r.set, tok0_r.literal};
  assign out_tuser  = tok0_r.kind;
  assign out_tlast  = tok0_r.last;

  `RPT_ASSERT_IMPLY(a_stall_only_when_full, !in_tready, out_tvalid)
  `RPT_ASSERT_IMPLY(a_end_closes_run, out_tvalid && (out_tuser == KIND_END), out_tlast)
  `RPT_ASSERT_IMPLY(a_class_no_literal, out_tvalid && (out_tuser == KIND_CLASS),
                    out_tdata[6:0] == 7'd0)
  `RPT_ASSERT_IMPLY(a_set_only_on_class, out_tvalid && (out_tuser != KIND_CLASS),
                    out_tdata[134:7] == 128'd0)
  `RPT_ASSERT_NEXT(a_last_char_ends, in_accept && in_tlast,
                   out_tvalid && (cnt_r != 2'd3))

endmodule

`default_nettype wire

>>> rtl/core/rpt_lexer.sv
`default_nettype none

module rpt_lexer
  import rpt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_accept,
  input  wire logic [CHAR_W-1:0]  in_char,
  input  wire logic               in_last,
  output rpt_burst_t              burst
);

  // characters with a meaning to the lexer
  localparam logic [CHAR_W-1:0] CH_LPAREN = 7'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 7'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_DASH   = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 7'h5B;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 7'h5D;
  localparam logic [CHAR_W-1:0] CH_CARET  = 7'h5E;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 7'h5F;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_PIPE   = 7'h7C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 7'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UC_D   = 7'h44;
  localparam logic [CHAR_W-1:0] CH_UC_S   = 7'h53;
  localparam logic [CHAR_W-1:0] CH_UC_W   = 7'h57;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 7'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LC_D   = 7'h64;
  localparam logic [CHAR_W-1:0] CH_LC_F   = 7'h66;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 7'h6E;
  localparam logic [CHAR_W-1:0] CH_LC_R   = 7'h72;
  localparam logic [CHAR_W-1:0] CH_LC_S   = 7'h73;
  localparam logic [CHAR_W-1:0] CH_LC_T   = 7'h74;
  localparam logic [CHAR_W-1:0] CH_LC_V   = 7'h76;
  localparam logic [CHAR_W-1:0] CH_LC_W   = 7'h77;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 7'h7A;
  localparam logic [CHAR_W-1:0] CH_TAB    = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_VT     = 7'h0B;
  localparam logic [CHAR_W-1:0] CH_FF     = 7'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;
  localparam logic [CHAR_W-1:0] CASE_BIT  = 7'h20;

  typedef enum logic [3:0] {
    M_NORMAL, M_ESC, M_QUOTE, M_QESC, M_COPEN,
    M_CLASS, M_CESC, M_CPEND, M_CDASH, M_CDESC
  } mode_t;

  // codes a..b inclusive, empty when a > b
  function automatic logic [SET_W-1:0] range_mask(input logic [CHAR_W-1:0] a,
                                                  input logic [CHAR_W-1:0] b);
    logic [SET_W-1:0] ones;
    ones = '1;
    return (ones << a) & (ones >> (7'd127 - b));
  endfunction

  // escape characters that stand for control codes
  function automatic logic [CHAR_W-1:0] unescape(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    case (c)
      CH_LC_N: r = CH_LF;
      CH_LC_T: r = CH_TAB;
      CH_LC_R: r = CH_CR;
      CH_LC_F: r = CH_FF;
      CH_LC_V: r = CH_VT;
      CH_ZERO: r = CH_NUL;
      default: r = c;
    endcase
    return r;
  endfunction

  // digit, word and space sets for d, w and s
  function automatic logic [SET_W-1:0] meta_set(input logic [CHAR_W-1:0] c);
    logic [SET_W-1:0] s;
    case (c)
      CH_LC_D: s = range_mask(CH_ZERO, CH_NINE);
      CH_LC_W: s = range_mask(CH_LC_A, CH_LC_Z) | range_mask(CH_UC_A, CH_UC_Z)
                 | range_mask(CH_ZERO, CH_NINE) | range_mask(CH_UNDER, CH_UNDER);
      CH_LC_S: s = range_mask(CH_SPACE, CH_SPACE) | range_mask(CH_TAB, CH_CR);
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic rpt_token_t make_tok(input kind_t k, input logic [CHAR_W-1:0] lit,
                                          input logic [SET_W-1:0] s);
    rpt_token_t t;
    t.kind    = k;
    t.literal = lit;
    t.set     = s;
    t.last    = 1'b0;
    return t;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic [SET_W-1:0]  bits_r, bits_nxt;
  logic              neg_r, neg_nxt;
  logic [CHAR_W-1:0] rs_r, rs_nxt;

  logic              meta_hit, meta_neg_hit;
  logic [SET_W-1:0]  ms, msl;

  // class shorthand decode after a backslash
  assign meta_hit     = in_char inside {CH_LC_D, CH_LC_W, CH_LC_S};
  assign meta_neg_hit = in_char inside {CH_UC_D, CH_UC_W, CH_UC_S};
  assign ms           = meta_set(in_char);
  assign msl          = meta_set(in_char | CASE_BIT);

  // next state and tokens for the current character
  always_comb begin
    logic        nrm, elem, ta_v, tb_v;
    rpt_token_t  ta, tb, te, t0, t1;
    logic [1:0]  n;
    mode_nxt = mode_r;
    bits_nxt = bits_r;
    neg_nxt  = neg_r;
    rs_nxt   = rs_r;
    nrm  = 1'b0;
    elem = 1'b0;
    ta_v = 1'b0;
    tb_v = 1'b0;
    ta   = make_tok(KIND_CHAR, in_char, '0);
    tb   = make_tok(KIND_CLASS, '0, '0);
    te   = make_tok(KIND_END, '0, '0);

    case (mode_r)
      M_NORMAL: nrm = 1'b1;
      M_ESC: begin
        mode_nxt = M_NORMAL;
        ta_v = 1'b1;
        if (meta_hit) ta = make_tok(KIND_CLASS, '0, ms);
        else if (meta_neg_hit) ta = make_tok(KIND_CLASS, '0, ~msl);
        else ta = make_tok(KIND_CHAR, unescape(in_char), '0);
      end
      M_QUOTE: begin
        if (in_char == CH_QUOTE) mode_nxt = M_NORMAL;
        else if (in_char == CH_BSLASH) mode_nxt = M_QESC;
        else ta_v = 1'b1;
      end
      M_QESC: begin
        ta_v = 1'b1;
        ta = make_tok(KIND_CHAR, unescape(in_char), '0);
        mode_nxt = M_QUOTE;
      end
      M_COPEN: begin
        if (in_char == CH_CARET) begin
          neg_nxt  = 1'b1;
          mode_nxt = M_CLASS;
        end else begin
          elem = 1'b1;
        end
      end
      M_CLASS: elem = 1'b1;
      M_CESC: begin
        mode_nxt = M_CLASS;
        if (meta_hit) begin
          bits_nxt = bits_nxt | ms;
        end else if (meta_neg_hit) begin
          bits_nxt = bits_nxt | ~msl;
        end else begin
          rs_nxt   = unescape(in_char);
          mode_nxt = M_CPEND;
        end
      end
      M_CPEND: begin
        if (in_char == CH_DASH && !in_last) begin
          mode_nxt = M_CDASH;
        end else begin
          bits_nxt = bits_nxt | range_mask(rs_r, rs_r);
          elem = 1'b1;
        end
      end
      M_CDASH: begin
        if (in_char == CH_BSLASH) begin
          mode_nxt = M_CDESC;
        end else begin
          bits_nxt = bits_nxt | range_mask(rs_r, in_char);
          mode_nxt = M_CLASS;
        end
      end
      M_CDESC: begin
        bits_nxt = bits_nxt | range_mask(rs_r, unescape(in_char));
        mode_nxt = M_CLASS;
      end
      default: begin
        mode_nxt = M_NORMAL;
        nrm = 1'b1;
      end
    endcase

    // top-level character: operators, openers or a literal
    if (nrm) begin
      case (in_char)
        CH_LPAREN: begin ta_v = 1'b1; ta = make_tok(KIND_LPAREN, in_char, '0); end
        CH_RPAREN: begin ta_v = 1'b1; ta = make_tok(KIND_RPAREN, in_char, '0); end
        CH_STAR:   begin ta_v = 1'b1; ta = make_tok(KIND_STAR, in_char, '0); end
        CH_PIPE:   begin ta_v = 1'b1; ta = make_tok(KIND_PIPE, in_char, '0); end
        CH_PLUS:   begin ta_v = 1'b1; ta = make_tok(KIND_PLUS, in_char, '0); end
        CH_QMARK:  begin ta_v = 1'b1; ta = make_tok(KIND_QUESTION, in_char, '0); end
        CH_LBRACK: mode_nxt = M_COPEN;
        CH_QUOTE:  mode_nxt = M_QUOTE;
        CH_BSLASH: mode_nxt = M_ESC;
        default:   ta_v = 1'b1;
      endcase
    end

    // element inside a class: close, escape or range start
    if (elem) begin
      if (in_char == CH_RBRACK) begin
        ta_v = 1'b1;
        ta = make_tok(KIND_CLASS, '0, neg_nxt ? ~bits_nxt : bits_nxt);
        mode_nxt = M_NORMAL;
        bits_nxt = '0;
        neg_nxt  = 1'b0;
        rs_nxt   = '0;
      end else if (in_char == CH_BSLASH) begin
        mode_nxt = M_CESC;
      end else begin
        rs_nxt   = in_char;
        mode_nxt = M_CPEND;
      end
    end

    // end of pattern: flush an open class, then back to reset state
    if (in_last) begin
      if (mode_nxt inside {[M_COPEN:M_CDESC]}) begin
        if (mode_nxt == M_CPEND) bits_nxt = bits_nxt | range_mask(rs_nxt, rs_nxt);
        tb_v = 1'b1;
        tb = make_tok(KIND_CLASS, '0, neg_nxt ? ~bits_nxt : bits_nxt);
      end
      mode_nxt = M_NORMAL;
      bits_nxt = '0;
      neg_nxt  = 1'b0;
      rs_nxt   = '0;
    end

    // pack the tokens in order, at most two
    t0 = te;
    t1 = te;
    n  = 2'd0;
    if (ta_v) begin
      t0 = ta;
      n  = 2'd1;
    end
    if (tb_v) begin
      if (n == 2'd0) t0 = tb;
      else t1 = tb;
      n = n + 2'd1;
    end
    if (in_last) begin
      if (n == 2'd0) t0 = te;
      else t1 = te;
      n = n + 2'd1;
    end
    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;
    burst.tok0  = t0;
    burst.tok1  = t1;
    burst.count = n;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      bits_r <= '0;
      neg_r  <= 1'b0;
      rs_r   <= '0;
    end else if (in_accept) begin
      mode_r <= mode_nxt;
      bits_r <= bits_nxt;
      neg_r  <= neg_nxt;
      rs_r   <= rs_nxt;
    end
  end

endmodule

`default_nettype wire
